### design/tio_pkg.sv
`default_nettype none

package tio_pkg;

    localparam int MaxPoints = 64;
    localparam int CountW    = $clog2(MaxPoints + 1);
    localparam int DenW      = $clog2(MaxPoints);
    localparam int TimeW     = 24;
    localparam int LevelW    = 17;
    localparam int TickW     = 16;
    localparam int CodeW     = 16;
    localparam int TpuW      = 8;
    localparam int LatW      = 4;
    localparam int CfgDataW  = 24;
    localparam int CfgIdxW   = 3;
    localparam int NumW      = LevelW + DenW + 3;
    localparam int MagW      = 16 + DenW;
    localparam int QuoW      = 15;
    localparam int DivDW     = MagW + QuoW;

    localparam logic [15:0] TenVolts = 16'd40960;

    localparam logic [CfgIdxW-1:0] CFG_TICKS_PER_US    = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_MIN_RAMP_STEP   = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_MIN_TICKS       = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_ANALOG_LATENCY  = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_DIGITAL_LATENCY = 3'd4;
    localparam logic [CfgIdxW-1:0] CFG_PIXEL_LATENCY   = 3'd5;

    localparam logic [1:0] CMD_ANALOG  = 2'd0;
    localparam logic [1:0] CMD_DIGITAL = 2'd1;
    localparam logic [1:0] CMD_PIXEL   = 2'd2;
    localparam logic [1:0] CMD_RAMP    = 2'd3;

    localparam logic [1:0] TS_OK  = 2'd0;
    localparam logic [1:0] TS_MAX = 2'd1;
    localparam logic [1:0] TS_MIN = 2'd2;

    localparam logic [1:0] LS_OK  = 2'd0;
    localparam logic [1:0] LS_POS = 2'd1;
    localparam logic [1:0] LS_NEG = 2'd2;

    localparam logic [1:0] RE_NONE   = 2'd0;
    localparam logic [1:0] RE_FEW    = 2'd1;
    localparam logic [1:0] RE_CAPPED = 2'd2;

    typedef enum logic [1:0] {
        KIND_ANALOG  = 2'd0,
        KIND_DIGITAL = 2'd1,
        KIND_ERROR   = 2'd2
    } kind_t;

    typedef struct packed {
        logic [TpuW-1:0]  ticks_per_us;
        logic [TimeW-1:0] min_ramp_step;
        logic [TickW-1:0] min_ticks;
        logic [LatW-1:0]  analog_latency;
        logic [LatW-1:0]  digital_latency;
        logic [LatW-1:0]  pixel_latency;
    } cfg_t;

    typedef struct packed {
        kind_t             kind;
        logic [TickW-1:0]  tick;
        logic [1:0]        ts;
        logic [LevelW-1:0] vi;
        logic [LevelW-1:0] vf;
        logic              dl;
        logic [DenW-1:0]   den;
        logic [CountW-1:0] count;
        logic              raised;
        logic [1:0]        err;
    } job_t;

endpackage

`default_nettype wire

### design/tio_if.sv
`default_nettype none

interface tio_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [23:0] hold_time;
    logic [16:0] level;
    logic [16:0] end_level;
    logic        digital_level;
    logic [23:0] ramp_length;

    modport source (output valid, command, hold_time, level, end_level, digital_level,
                    ramp_length, input ready);
    modport sink (input valid, command, hold_time, level, end_level, digital_level,
                  ramp_length, output ready);
endinterface

interface tio_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] instruction_word;
    logic [1:0]  time_status;
    logic [1:0]  level_status;
    logic        step_raised;
    logic [1:0]  ramp_error;
    logic        last;

    modport source (output valid, instruction_word, time_status, level_status,
                    step_raised, ramp_error, last, input ready);
    modport sink (input valid, instruction_word, time_status, level_status,
                  step_raised, ramp_error, last, output ready);
endinterface

`default_nettype wire

### design/tio_front.sv
`default_nettype none

module tio_front
    import tio_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire cfg_t cfg,
    tio_in_if.sink    item,
    output job_t      job,
    output logic      push,
    input  wire logic full
);

    typedef enum logic [4:0] {
        F_IDLE = 5'b00001,
        F_MUL  = 5'b00010,
        F_TICK = 5'b00100,
        F_DIV  = 5'b01000,
        F_PUSH = 5'b10000
    } fstate_t;

    fstate_t state_reg, state_next;

    logic [1:0]        cmd_reg;
    logic [TimeW-1:0]  step_reg;
    logic [LevelW-1:0] vi_reg;
    logic [LevelW-1:0] vf_reg;
    logic              dl_reg;
    logic              raised_reg;
    logic [31:0]       prod_reg;
    logic [TickW-1:0]  tick_reg, tick_next;
    logic [1:0]        ts_reg, ts_next;
    logic [TimeW-1:0]  quot_reg;
    logic [TimeW:0]    rem_reg;
    logic [4:0]        cnt_reg;

    logic [TimeW-1:0]  ticks_raw;
    logic [TickW-1:0]  ticks_clamped;
    logic [LatW-1:0]   lat;
    logic [TimeW:0]    rem_shift;
    logic              step_low;
    logic [CountW-1:0] m_count;
    logic              capped;

    assign item.ready = (state_reg == F_IDLE);
    assign step_low   = (item.command == CMD_RAMP) && (item.hold_time < cfg.min_ramp_step);

    always_comb
    begin
        ticks_raw = prod_reg[31:8];
        ts_next   = TS_OK;
        if (ticks_raw > TimeW'(16'hFFFF))
        begin
            ticks_clamped = 16'hFFFF;
            ts_next       = TS_MAX;
        end
        else if (ticks_raw[TickW-1:0] < cfg.min_ticks)
        begin
            ticks_clamped = cfg.min_ticks;
            ts_next       = TS_MIN;
        end
        else
        begin
            ticks_clamped = ticks_raw[TickW-1:0];
        end
        case (cmd_reg)
            CMD_DIGITAL: lat = cfg.digital_latency;
            CMD_PIXEL:   lat = cfg.pixel_latency;
            default:     lat = cfg.analog_latency;
        endcase
        tick_next = ticks_clamped - TickW'(lat);
    end

    assign rem_shift = {rem_reg[TimeW-1:0], quot_reg[TimeW-1]};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (item.valid)
                begin
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                state_next = F_TICK;
            end
            F_TICK:
            begin
                if (cmd_reg == CMD_RAMP && step_reg != '0)
                begin
                    state_next = F_DIV;
                end
                else
                begin
                    state_next = F_PUSH;
                end
            end
            F_DIV:
            begin
                if (cnt_reg == 5'(TimeW - 1))
                begin
                    state_next = F_PUSH;
                end
            end
            F_PUSH:
            begin
                if (!full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                cmd_reg    <= item.command;
                step_reg   <= step_low ? cfg.min_ramp_step : item.hold_time;
                raised_reg <= step_low;
                vi_reg     <= item.level;
                vf_reg     <= item.end_level;
                dl_reg     <= item.digital_level;
                quot_reg   <= item.ramp_length;
            end
            F_MUL:
            begin
                prod_reg <= 32'(step_reg) * 32'(cfg.ticks_per_us);
            end
            F_TICK:
            begin
                tick_reg <= tick_next;
                ts_reg   <= ts_next;
                rem_reg  <= '0;
                cnt_reg  <= '0;
                if (step_reg == '0)
                begin
                    quot_reg <= '0;
                end
            end
            F_DIV:
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (rem_shift >= {1'b0, step_reg})
                begin
                    rem_reg  <= rem_shift - {1'b0, step_reg};
                    quot_reg <= {quot_reg[TimeW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_shift;
                    quot_reg <= {quot_reg[TimeW-2:0], 1'b0};
                end
            end
            default:
            begin
            end
        endcase
    end

    assign capped  = quot_reg > TimeW'(MaxPoints);
    assign m_count = capped ? CountW'(MaxPoints) : quot_reg[CountW-1:0];
    assign push    = (state_reg == F_PUSH) && !full;

    always_comb
    begin
        job.tick   = tick_reg;
        job.ts     = ts_reg;
        job.vi     = vi_reg;
        job.vf     = vf_reg;
        job.dl     = dl_reg;
        job.raised = raised_reg;
        job.err    = RE_NONE;
        job.den    = DenW'(1);
        job.count  = CountW'(1);
        case (cmd_reg)
            CMD_ANALOG:
            begin
                job.kind = KIND_ANALOG;
            end
            CMD_RAMP:
            begin
                if (quot_reg <= TimeW'(1))
                begin
                    job.kind = KIND_ERROR;
                    job.err  = RE_FEW;
                end
                else
                begin
                    job.kind  = KIND_ANALOG;
                    job.err   = capped ? RE_CAPPED : RE_NONE;
                    job.count = m_count;
                    job.den   = DenW'(m_count - CountW'(1));
                end
            end
            default:
            begin
                job.kind = KIND_DIGITAL;
            end
        endcase
    end

endmodule

`default_nettype wire

### design/tio_queue.sv
`default_nettype none

module tio_queue
    import tio_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire job_t wr_job,
    input  wire logic push,
    output logic      full,
    output job_t      rd_job,
    input  wire logic pop,
    output logic      empty
);

    job_t       mem [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;

    assign full   = (fill_reg == 2'd2);
    assign empty  = (fill_reg == 2'd0);
    assign rd_job = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                fill_reg <= fill_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                fill_reg <= fill_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

### design/tio_back.sv
`default_nettype none

module tio_back
    import tio_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire job_t head,
    input  wire logic empty,
    output logic      pop,
    tio_out_if.source result
);

    typedef enum logic [4:0] {
        B_IDLE  = 5'b00001,
        B_NUM   = 5'b00010,
        B_CLAMP = 5'b00100,
        B_DIV   = 5'b01000,
        B_EMIT  = 5'b10000
    } bstate_t;

    bstate_t state_reg, state_next;

    job_t                   job_reg;
    logic [CountW-1:0]      idx_reg;
    logic signed [NumW-1:0] num_reg;
    logic [CodeW-1:0]       code_reg;
    logic [1:0]             ls_reg;
    logic                   neg_reg;
    logic [MagW-1:0]        dvs_reg;
    logic [DivDW-1:0]       rem_reg;
    logic [QuoW-1:0]        quo_reg;
    logic [3:0]             k_reg;

    logic                   out_valid_reg;
    logic [31:0]            word_reg;
    logic [1:0]             ts_out_reg;
    logic [1:0]             ls_out_reg;
    logic                   sr_out_reg;
    logic [1:0]             re_out_reg;
    logic                   last_out_reg;

    logic signed [NumW-1:0] vi_ext, vf_ext, den_ext, idx_ext, num_next;
    logic [MagW-1:0]        lim;
    logic signed [NumW-1:0] lim_s;
    logic [NumW-1:0]        num_abs;
    logic [MagW-1:0]        mag;
    logic [DivDW-1:0]       dsh;
    logic [QuoW-1:0]        quo_next;
    logic                   load;
    logic                   more;

    assign vi_ext   = NumW'($signed(job_reg.vi));
    assign vf_ext   = NumW'($signed(job_reg.vf));
    assign den_ext  = $signed(NumW'(job_reg.den));
    assign idx_ext  = $signed(NumW'(idx_reg));
    assign num_next = vi_ext * den_ext + (vf_ext - vi_ext) * idx_ext;

    assign lim     = MagW'(TenVolts) * MagW'(job_reg.den);
    assign lim_s   = $signed(NumW'(lim));
    assign num_abs = num_reg[NumW-1] ? NumW'(-num_reg) : NumW'(num_reg);
    assign mag     = num_abs[MagW-1:0];

    assign dsh      = DivDW'(dvs_reg) << k_reg;
    assign quo_next = (rem_reg >= dsh) ? (quo_reg | (QuoW'(1) << k_reg)) : quo_reg;

    assign load = (state_reg == B_EMIT) && (!out_valid_reg || result.ready);
    assign more = (job_reg.kind == KIND_ANALOG) && (CountW'(idx_reg + CountW'(1)) != job_reg.count);
    assign pop  = (state_reg == B_IDLE) && !empty;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                begin
                    state_next = (head.kind == KIND_ANALOG) ? B_NUM : B_EMIT;
                end
            end
            B_NUM:
            begin
                state_next = B_CLAMP;
            end
            B_CLAMP:
            begin
                if (num_reg > lim_s || num_reg < -lim_s)
                begin
                    state_next = B_EMIT;
                end
                else
                begin
                    state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                if (k_reg == 4'd0)
                begin
                    state_next = B_EMIT;
                end
            end
            B_EMIT:
            begin
                if (load)
                begin
                    state_next = more ? B_NUM : B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            B_IDLE:
            begin
                job_reg  <= head;
                idx_reg  <= '0;
                code_reg <= {{(CodeW-1){1'b0}}, head.dl};
                ls_reg   <= LS_OK;
            end
            B_NUM:
            begin
                num_reg <= num_next;
            end
            B_CLAMP:
            begin
                neg_reg <= num_reg[NumW-1];
                dvs_reg <= lim;
                rem_reg <= (DivDW'(mag) << QuoW) - DivDW'(mag);
                quo_reg <= '0;
                k_reg   <= 4'(QuoW - 1);
                ls_reg  <= LS_OK;
                if (num_reg > lim_s)
                begin
                    code_reg <= 16'h7FFF;
                    ls_reg   <= LS_POS;
                end
                else if (num_reg < -lim_s)
                begin
                    code_reg <= 16'h8000;
                    ls_reg   <= LS_NEG;
                end
            end
            B_DIV:
            begin
                quo_reg <= quo_next;
                k_reg   <= k_reg - 4'd1;
                if (rem_reg >= dsh)
                begin
                    rem_reg <= rem_reg - dsh;
                end
                if (k_reg == 4'd0)
                begin
                    code_reg <= neg_reg ? CodeW'(-CodeW'(quo_next)) : CodeW'(quo_next);
                end
            end
            B_EMIT:
            begin
                if (load)
                begin
                    idx_reg <= idx_reg + CountW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sr_out_reg   <= job_reg.raised;
            re_out_reg   <= job_reg.err;
            last_out_reg <= !more;
            if (job_reg.kind == KIND_ERROR)
            begin
                word_reg   <= '0;
                ts_out_reg <= TS_OK;
                ls_out_reg <= LS_OK;
            end
            else
            begin
                word_reg   <= {job_reg.tick, code_reg};
                ts_out_reg <= job_reg.ts;
                ls_out_reg <= ls_reg;
            end
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.instruction_word = word_reg;
    assign result.time_status      = ts_out_reg;
    assign result.level_status     = ls_out_reg;
    assign result.step_raised      = sr_out_reg;
    assign result.ramp_error       = re_out_reg;
    assign result.last             = last_out_reg;

endmodule

`default_nettype wire

### design/timed_output_instruction_builder.sv
// Path: a digital or pixel word passes F_MUL, F_TICK, F_PUSH, the two-entry queue, B_IDLE
// and B_EMIT; an analog word also passes B_NUM, B_CLAMP and B_DIV (B_DIV skipped when clamped).
// A ramp's first word also waits for the 24-step length divider (F_DIV). The front end takes
// one command at a time, and B_EMIT holds while a registered result is waiting and ready is low.
// Reset clears all control state and loads the configuration registers with their defaults.
`default_nettype none

module timed_output_instruction_builder
    import tio_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    tio_in_if.sink                   item,
    tio_out_if.source                result,
    input  wire logic                cfg_write,
    input  wire logic [CfgIdxW-1:0]  cfg_index,
    input  wire logic [CfgDataW-1:0] cfg_data
);

    cfg_t cfg_reg;
    job_t front_job;
    job_t head_job;
    logic push;
    logic pop;
    logic full;
    logic empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ticks_per_us    <= 8'd160;
            cfg_reg.min_ramp_step   <= 24'd256;
            cfg_reg.min_ticks       <= 16'd2;
            cfg_reg.analog_latency  <= 4'd2;
            cfg_reg.digital_latency <= 4'd2;
            cfg_reg.pixel_latency   <= 4'd1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_TICKS_PER_US:    cfg_reg.ticks_per_us    <= cfg_data[TpuW-1:0];
                CFG_MIN_RAMP_STEP:   cfg_reg.min_ramp_step   <= cfg_data[TimeW-1:0];
                CFG_MIN_TICKS:       cfg_reg.min_ticks       <= cfg_data[TickW-1:0];
                CFG_ANALOG_LATENCY:  cfg_reg.analog_latency  <= cfg_data[LatW-1:0];
                CFG_DIGITAL_LATENCY: cfg_reg.digital_latency <= cfg_data[LatW-1:0];
                CFG_PIXEL_LATENCY:   cfg_reg.pixel_latency   <= cfg_data[LatW-1:0];
                default:
                begin
                end
            endcase
        end
    end

    tio_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .item  (item),
        .job   (front_job),
        .push  (push),
        .full  (full)
    );

    tio_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_job (front_job),
        .push   (push),
        .full   (full),
        .rd_job (head_job),
        .pop    (pop),
        .empty  (empty)
    );

    tio_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head_job),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

endmodule

`default_nettype wire
